/* rtl/pct_pkg.sv */
// ----------------------------------------------------------------------------
// pct_pkg
// Shared types and constants for the pointer cursor tracker.
// ----------------------------------------------------------------------------
package pct_pkg;

    localparam int COORD_BITS_DEF = 15;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int DIV_BITS       = 64;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_W  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_H  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPEED     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_CAP       = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_TRIGGER   = 3'd6;

    // Report types
    localparam logic [1:0] REQ_ABS      = 2'd0;
    localparam logic [1:0] REQ_REL      = 2'd1;
    localparam logic [1:0] REQ_NOTREADY = 2'd2;
    localparam logic [1:0] REQ_ERROR    = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture the input transaction
        logic mul_x;     // form the X dividend
        logic mul_y;     // form the Y dividend
        logic div_x;     // start the X division
        logic div_y;     // start the Y division
        logic div_step;  // advance the divider by one bit
        logic commit;    // update cursor, counters and result
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic needs_div; // first good report of the round, division needed
        logic div_last;  // divider on its final bit
    } t_sts;

endpackage

/* rtl/pct_ctrl.sv */
// ----------------------------------------------------------------------------
// pct_ctrl
// Sequencer: accept, two serial divisions when needed, commit, hold result.
// ----------------------------------------------------------------------------
module pct_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    output pct_pkg::t_cmd o_cmd,
    input  pct_pkg::t_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE, S_MULX, S_DIVX, S_MULY, S_DIVY, S_COMMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   w_acc, w_free;

    // Output register frees when empty or taken
    assign w_free  = !r_ovalid || !i_stall;
    assign w_acc   = (r_state == S_IDLE) && i_valid;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;

    always_comb begin
        n_state = r_state;
        n_ovalid = r_ovalid && i_stall;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    o_cmd.load = 1'b1;
                    n_state = S_MULX;
                end
            end
            S_MULX: begin
                if (i_sts.needs_div) begin
                    o_cmd.mul_x = 1'b1;
                    n_state = S_DIVX;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_DIVX: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_MULY;
                end
            end
            S_MULY: begin
                o_cmd.mul_y = 1'b1;
                n_state = S_DIVY;
            end
            S_DIVY: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (w_free) begin
                    o_cmd.commit = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd.div_x = o_cmd.mul_x;
        o_cmd.div_y = o_cmd.mul_y;
    end

    // Hold state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

/* rtl/pct_dp.sv */
// ----------------------------------------------------------------------------
// pct_dp
// Datapath: config registers, cursor state, bit-serial divider, result.
// ----------------------------------------------------------------------------
module pct_dp #(
    parameter int COORD_BITS = pct_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pct_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [pct_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic [1:0]                         i_req_type,
    input  logic [31:0]                        i_abs_x,
    input  logic [31:0]                        i_abs_y,
    input  logic signed [31:0]                 i_rel_x,
    input  logic signed [31:0]                 i_rel_y,
    input  logic [31:0]                        i_divisor_x,
    input  logic [31:0]                        i_divisor_y,
    input  logic                               i_button,
    input  logic                               i_last_in_poll,
    input  pct_pkg::t_cmd                      i_cmd,
    output pct_pkg::t_sts                      o_sts,
    output logic                               o_status,
    output logic [15:0]                        o_stall_us,
    output logic                               o_round_done,
    output logic [COORD_BITS-1:0]              o_cursor_x,
    output logic [COORD_BITS-1:0]              o_cursor_y,
    output logic                               o_holding,
    output logic                               o_press
);

    localparam int DB = pct_pkg::DIV_BITS;
    localparam int CB = $clog2(DB);

    // Configuration
    logic [COORD_BITS-1:0] r_sw, r_sh;
    logic [4:0]  r_speed;
    logic        r_active;
    logic [15:0] r_step, r_cap;
    logic [3:0]  r_trig;

    // Captured transaction
    logic [1:0]  r_type;
    logic [31:0] r_ax, r_ay, r_rx, r_ry, r_dx, r_dy;
    logic        r_btn, r_last;

    // Cursor state
    logic [COORD_BITS-1:0] r_cx, r_cy, r_nx;
    logic        r_hold, r_prev, r_press, r_found;
    logic [3:0]  r_nrc;
    logic [15:0] r_delay;

    // Divider: magnitude restoring division
    logic [DB-1:0] r_num, r_quo;
    logic [DB:0]   r_rem;
    logic [DB-1:0] r_den;
    logic          r_neg;
    logic [CB-1:0] r_cnt;

    logic                  r_is_y_d, r_type_abs_d;
    logic [COORD_BITS-1:0] r_size_d;

    logic [COORD_BITS-1:0] w_w, w_h;
    logic [1:0]            w_type;
    logic                  w_is_y;
    logic [31:0]           w_pos, w_rel, w_div;
    logic [COORD_BITS-1:0] w_size;
    logic signed [37:0]    w_prod;
    logic [DB-1:0]         w_dividend;
    logic [DB:0]           w_trial;
    logic [DB-1:0]         w_q_next;
    logic [COORD_BITS-1:0] w_coord;
    logic signed [DB+1:0]  w_t;
    logic [DB-1:0]         w_abs_q;

    assign w_w = (r_sw == '0) ? COORD_BITS'(1) : r_sw;
    assign w_h = (r_sh == '0) ? COORD_BITS'(1) : r_sh;

    // Zero divisor turns a good report into an error
    assign w_type = (r_type <= pct_pkg::REQ_REL && (r_dx == '0 || r_dy == '0))
                    ? pct_pkg::REQ_ERROR : r_type;

    assign o_sts.needs_div = r_active && !r_found && (w_type <= pct_pkg::REQ_REL);
    assign o_sts.div_last  = (r_cnt == '0);

    // Dividend for the axis being started
    assign w_is_y = i_cmd.mul_y;
    assign w_pos  = w_is_y ? r_ay : r_ax;
    assign w_rel  = w_is_y ? r_ry : r_rx;
    assign w_div  = w_is_y ? r_dy : r_dx;
    assign w_size = w_is_y ? w_h : w_w;
    assign w_prod = $signed(w_rel) * $signed({1'b0, r_speed});
    always_comb begin
        if (w_type == pct_pkg::REQ_ABS) begin
            w_dividend = DB'(w_pos) * DB'(w_size);
        end else if (w_prod < 0) begin
            w_dividend = DB'(-w_prod);
        end else begin
            w_dividend = DB'(w_prod);
        end
    end

    // One quotient bit per step
    assign w_trial  = {r_rem[DB-1:0], r_num[DB-1]} - {1'b0, r_den};
    assign w_q_next = {r_quo[DB-2:0], !w_trial[DB]};

    // Finish the axis: saturate or add and clamp
    always_comb begin
        w_abs_q = w_q_next;
        w_t = r_neg ? -$signed({2'b00, w_abs_q}) : $signed({2'b00, w_abs_q});
        w_t = w_t + $signed({{(DB+2-COORD_BITS){1'b0}}, (i_cmd.div_step && r_cnt == '0 &&
              r_is_y_d) ? r_cy : r_cx});
        if (r_type_abs_d) begin
            w_coord = (w_abs_q > DB'(r_size_d)) ? r_size_d : w_abs_q[COORD_BITS-1:0];
        end else if (w_t < 0) begin
            w_coord = '0;
        end else if (w_t >= $signed({{(DB+2-COORD_BITS){1'b0}}, r_size_d})) begin
            w_coord = r_size_d - 1'b1;
        end else begin
            w_coord = w_t[COORD_BITS-1:0];
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw     <= COORD_BITS'(1024);
            r_sh     <= COORD_BITS'(768);
            r_speed  <= 5'd4;
            r_active <= 1'b0;
            r_step   <= 16'd1000;
            r_cap    <= 16'd50000;
            r_trig   <= 4'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pct_pkg::REG_SCREEN_W: r_sw     <= i_cfg_data[COORD_BITS-1:0];
                pct_pkg::REG_SCREEN_H: r_sh     <= i_cfg_data[COORD_BITS-1:0];
                pct_pkg::REG_SPEED:    r_speed  <= i_cfg_data[4:0];
                pct_pkg::REG_ACTIVE:   r_active <= i_cfg_data[0];
                pct_pkg::REG_STEP:     r_step   <= i_cfg_data;
                pct_pkg::REG_CAP:      r_cap    <= i_cfg_data;
                pct_pkg::REG_TRIGGER:  r_trig   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Capture transaction and run divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type <= i_req_type;
            r_ax <= i_abs_x;   r_ay <= i_abs_y;
            r_rx <= i_rel_x;   r_ry <= i_rel_y;
            r_dx <= i_divisor_x; r_dy <= i_divisor_y;
            r_btn <= i_button; r_last <= i_last_in_poll;
        end
        if (i_cmd.div_x || i_cmd.div_y) begin
            r_num <= w_dividend;
            r_den <= DB'(w_div);
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= CB'(DB-1);
            r_neg <= (w_type != pct_pkg::REQ_ABS) && (w_prod < 0);
            r_is_y_d <= w_is_y;
            r_type_abs_d <= (w_type == pct_pkg::REQ_ABS);
            r_size_d <= w_size;
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[DB-2:0], 1'b0};
            r_rem <= w_trial[DB] ? {r_rem[DB-1:0], r_num[DB-1]} : w_trial;
            r_quo <= w_q_next;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Cursor, counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= COORD_BITS'(512);
            r_cy <= COORD_BITS'(384);
            r_nx <= '0;
            r_hold <= 1'b0; r_prev <= 1'b0; r_press <= 1'b0; r_found <= 1'b0;
            r_nrc <= '0; r_delay <= '0;
            o_status <= 1'b0; o_stall_us <= '0; o_round_done <= 1'b0;
            o_cursor_x <= '0; o_cursor_y <= '0; o_holding <= 1'b0; o_press <= 1'b0;
        end else begin
            // Park the X result until Y is done
            if (i_cmd.div_step && r_cnt == '0) begin
                if (r_is_y_d) begin
                    r_cy <= w_coord;
                    r_cx <= r_nx;
                end else begin
                    r_nx <= w_coord;
                end
            end
            if (i_cmd.commit) begin
                logic        v_hold, v_press;
                logic [3:0]  v_nrc;
                logic [16:0] v_d;
                logic [15:0] v_stall;
                v_hold = r_hold; v_press = r_press; v_nrc = r_nrc; v_stall = '0;
                v_d = '0;
                if (r_active) begin
                    if (w_type <= pct_pkg::REQ_REL) begin
                        v_nrc = '0;
                        if (!r_found) begin
                            v_hold = r_btn;
                        end
                    end else if (w_type == pct_pkg::REQ_NOTREADY) begin
                        v_nrc = r_nrc + 1'b1;
                        if (v_nrc >= r_trig) begin
                            v_d = {1'b0, r_delay} + {1'b0, r_step};
                            v_stall = (v_d > {1'b0, r_cap}) ? r_cap : v_d[15:0];
                            r_delay <= v_stall;
                            v_nrc = '0;
                        end
                    end else begin
                        v_nrc = '0;
                    end
                    r_found <= (r_found || (w_type <= pct_pkg::REQ_REL)) && !r_last;
                    if (r_last) begin
                        v_press = r_prev && !v_hold;
                        r_prev  <= v_hold;
                    end
                end
                r_hold  <= v_hold;
                r_press <= v_press;
                r_nrc   <= v_nrc;
                o_status     <= !r_active;
                o_stall_us   <= v_stall;
                o_round_done <= r_active && r_last;
                o_cursor_x   <= r_cx;
                o_cursor_y   <= r_cy;
                o_holding    <= v_hold;
                o_press      <= v_press;
            end
        end
    end

endmodule

/* rtl/pointer_cursor_tracker_unit.sv */
// ----------------------------------------------------------------------------
// pointer_cursor_tracker_unit
// Tracks a screen cursor from pointer poll reports.
// ----------------------------------------------------------------------------
//  channel | signals                       | direction
//  input   | i_valid / o_stall, fields     | in
//  result  | o_valid / i_stall, fields     | out
//  config  | i_cfg_we, i_cfg_idx, data     | in
// A report with no division goes straight to commit; otherwise the
// shared bit-serial divider runs once per axis, X then Y.
// Reset is synchronous and active low; no clearing pass follows it.
// One result register parts the sides; a stalled result holds.
module pointer_cursor_tracker_unit #(
    parameter int COORD_BITS = pct_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pct_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [pct_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_req_type,
    input  logic [31:0]                       i_abs_x,
    input  logic [31:0]                       i_abs_y,
    input  logic signed [31:0]                i_rel_x,
    input  logic signed [31:0]                i_rel_y,
    input  logic [31:0]                       i_divisor_x,
    input  logic [31:0]                       i_divisor_y,
    input  logic                              i_button,
    input  logic                              i_last_in_poll,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_status,
    output logic [15:0]                       o_stall_us,
    output logic                              o_round_done,
    output logic [COORD_BITS-1:0]             o_cursor_x,
    output logic [COORD_BITS-1:0]             o_cursor_y,
    output logic                              o_holding,
    output logic                              o_press
);

    pct_pkg::t_cmd w_cmd;
    pct_pkg::t_sts w_sts;

    pct_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_cmd(w_cmd), .i_sts(w_sts)
    );

    pct_dp #(.COORD_BITS(COORD_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_req_type(i_req_type), .i_abs_x(i_abs_x), .i_abs_y(i_abs_y),
        .i_rel_x(i_rel_x), .i_rel_y(i_rel_y),
        .i_divisor_x(i_divisor_x), .i_divisor_y(i_divisor_y),
        .i_button(i_button), .i_last_in_poll(i_last_in_poll),
        .i_cmd(w_cmd), .o_sts(w_sts),
        .o_status(o_status), .o_stall_us(o_stall_us), .o_round_done(o_round_done),
        .o_cursor_x(o_cursor_x), .o_cursor_y(o_cursor_y),
        .o_holding(o_holding), .o_press(o_press)
    );

endmodule

/* dv/tb_pointer_cursor_tracker_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pointer_cursor_tracker_unit
// Self-checking bench for the pointer cursor tracker. Poll rounds of absolute,
// relative, not-ready and error reports are queued under several register
// settings. Each is scored by an in-bench cursor predictor, and every result
// transaction is checked field by field against it, under random bursts,
// gaps and stalls.
// ----------------------------------------------------------------------------
module tb_pointer_cursor_tracker_unit;

    localparam int RUN_LIMIT = 3000000;

    typedef struct {
        logic [1:0]         kind;
        logic [31:0]        ax, ay;
        logic signed [31:0] rx, ry;
        logic [31:0]        dx, dy;
        logic               btn, last;
    } t_report;

    typedef struct {
        logic        status;
        logic [15:0] stall_us;
        logic        done;
        logic [14:0] cx, cy;
        logic        hold, press;
    } t_cursor;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [pct_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [pct_pkg::CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_req_type = pct_pkg::REQ_ERROR;
    logic [31:0] i_abs_x = '0, i_abs_y = '0;
    logic signed [31:0] i_rel_x = '0, i_rel_y = '0;
    logic [31:0] i_divisor_x = '0, i_divisor_y = '0;
    logic i_button = 1'b0, i_last_in_poll = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_status, o_round_done, o_holding, o_press;
    logic [15:0] o_stall_us;
    logic [14:0] o_cursor_x, o_cursor_y;

    pointer_cursor_tracker_unit u_top (.*);

    // clock, 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor copy of registers and tracker state
    logic [14:0] sw = 15'd1024, sh = 15'd768;
    logic [4:0]  speed = 5'd4;
    logic        active = 1'b0;
    logic [15:0] step_us = 16'd1000, cap_us = 16'd50000;
    logic [3:0]  trigger = 4'd3;
    logic [14:0] cur_x = 15'd512, cur_y = 15'd384;
    logic        hold_r = 1'b0, prev_hold = 1'b0, press_r = 1'b0, found = 1'b0;
    logic [3:0]  nr_count = '0;
    logic [15:0] delay_us = '0;

    t_report report_q[$];
    t_cursor cursor_q[$];
    int      mismatches = 0;
    int      cycles = 0;

    function automatic logic [14:0] scale_abs(logic [31:0] pos, logic [14:0] size,
                                              logic [31:0] div);
        logic [63:0] q;
        q = (64'(pos) * 64'(size)) / 64'(div);
        return (q > 64'(size)) ? size : q[14:0];
    endfunction

    function automatic logic [14:0] move_rel(logic [14:0] cur, logic signed [31:0] mv,
                                             logic [31:0] div, logic [14:0] size);
        longint t;
        t = longint'(cur) + (longint'(mv) * longint'(speed)) / longint'({32'b0, div});
        if (t < 0) return '0;
        if (t >= longint'(size)) return size - 15'd1;
        return t[14:0];
    endfunction

    // advance the tracker state by one report and return its result
    function automatic t_cursor track_report(t_report r);
        t_cursor     c;
        logic [1:0]  kind;
        logic [14:0] w, h;
        logic [16:0] d;
        c = '{default: '0};
        kind = r.kind;
        if (!active) begin
            c.status = 1'b1;
        end else begin
            w = (sw == 0) ? 15'd1 : sw;
            h = (sh == 0) ? 15'd1 : sh;
            if (kind <= pct_pkg::REQ_REL && (r.dx == 0 || r.dy == 0))
                kind = pct_pkg::REQ_ERROR;
            if (kind == pct_pkg::REQ_ABS || kind == pct_pkg::REQ_REL) begin
                nr_count = '0;
                if (!found) begin
                    found = 1'b1;
                    if (kind == pct_pkg::REQ_ABS) begin
                        cur_x = scale_abs(r.ax, w, r.dx);
                        cur_y = scale_abs(r.ay, h, r.dy);
                    end else begin
                        cur_x = move_rel(cur_x, r.rx, r.dx, w);
                        cur_y = move_rel(cur_y, r.ry, r.dy, h);
                    end
                    hold_r = r.btn;
                end
            end else if (kind == pct_pkg::REQ_NOTREADY) begin
                nr_count = nr_count + 4'd1;
                if (nr_count >= trigger) begin
                    d = 17'(delay_us) + 17'(step_us);
                    delay_us = (d > 17'(cap_us)) ? cap_us : d[15:0];
                    c.stall_us = delay_us;
                    nr_count = '0;
                end
            end else begin
                nr_count = '0;
            end
            if (r.last) begin
                press_r = prev_hold && !hold_r;
                prev_hold = hold_r;
                found = 1'b0;
                c.done = 1'b1;
            end
        end
        c.cx = cur_x;
        c.cy = cur_y;
        c.hold = hold_r;
        c.press = press_r;
        return c;
    endfunction

    task automatic queue_report(logic [1:0] kind, logic [31:0] ax, logic [31:0] ay,
                                logic [31:0] rx, logic [31:0] ry, logic [31:0] dx,
                                logic [31:0] dy, logic btn, logic last);
        t_report r;
        r = '{kind, ax, ay, rx, ry, dx, dy, btn, last};
        cursor_q.push_back(track_report(r));
        report_q.push_back(r);
    endtask

    task automatic wait_idle();
        while (report_q.size() != 0 || cursor_q.size() != 0) @(posedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [pct_pkg::CFG_IDX_BITS-1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            pct_pkg::REG_SCREEN_W: sw = val[14:0];
            pct_pkg::REG_SCREEN_H: sh = val[14:0];
            pct_pkg::REG_SPEED:    speed = val[4:0];
            pct_pkg::REG_ACTIVE:   active = val[0];
            pct_pkg::REG_STEP:     step_us = val;
            pct_pkg::REG_CAP:      cap_us = val;
            pct_pkg::REG_TRIGGER:  trigger = val[3:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [15:0] w, logic [15:0] h, logic [15:0] spd,
                             logic [15:0] act, logic [15:0] stp, logic [15:0] cp,
                             logic [15:0] trg);
        wait_idle();
        write_reg(pct_pkg::REG_SCREEN_W, w);
        write_reg(pct_pkg::REG_SCREEN_H, h);
        write_reg(pct_pkg::REG_SPEED, spd);
        write_reg(pct_pkg::REG_ACTIVE, act);
        write_reg(pct_pkg::REG_STEP, stp);
        write_reg(pct_pkg::REG_CAP, cp);
        write_reg(pct_pkg::REG_TRIGGER, trg);
    endtask

    // one poll round of random content; mostly well formed
    task automatic random_round();
        int          n, k;
        logic [1:0]  kind;
        logic [31:0] dx, dy, rx, ry;
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            kind = (k < 35) ? pct_pkg::REQ_ABS : (k < 65) ? pct_pkg::REQ_REL :
                   (k < 90) ? pct_pkg::REQ_NOTREADY : pct_pkg::REQ_ERROR;
            dx = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 4096);
            dy = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 4096);
            if ($urandom_range(0, 19) == 0) dx = 0;
            if ($urandom_range(0, 19) == 0) dy = 0;
            rx = ($urandom_range(0, 3) == 0) ? $urandom :
                 32'($signed($urandom_range(0, 4000)) - 2000);
            ry = ($urandom_range(0, 3) == 0) ? $urandom :
                 32'($signed($urandom_range(0, 4000)) - 2000);
            queue_report(kind, $urandom, $urandom, rx, ry, dx, dy, $urandom_range(0, 1),
                         (i == n - 1) ? 1'b1 : ($urandom_range(0, 15) == 0));
        end
    endtask

    task automatic random_phase(int rounds);
        for (int i = 0; i < rounds; i++) random_round();
    endtask

    // stimulus
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // inactive pointer: everything ignored, last mark included
        queue_report(pct_pkg::REQ_ABS, 32'd100, 32'd100, 0, 0, 32'd200, 32'd200, 1'b1, 1'b1);
        queue_report(pct_pkg::REQ_NOTREADY, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1);

        write_all(16'd1024, 16'd768, 16'd4, 16'd1, 16'd1000, 16'd50000, 16'd3);
        // directed: extremes, every report kind, press edges
        queue_report(pct_pkg::REQ_ABS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 32'd1, 32'd1,
                     1'b1, 1'b0);
        queue_report(pct_pkg::REQ_ABS, 0, 0, 0, 0, 32'd1, 32'd1, 1'b0, 1'b1);
        queue_report(pct_pkg::REQ_ABS, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        queue_report(pct_pkg::REQ_REL, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd1,
                     1'b0, 1'b1);
        queue_report(pct_pkg::REQ_REL, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd1,
                     1'b1, 1'b1);
        queue_report(pct_pkg::REQ_REL, 0, 0, 32'hFFFF_FFF9, 32'd7, 32'd3, 32'd3, 1'b1, 1'b1);
        queue_report(pct_pkg::REQ_REL, 0, 0, 32'hFFFF_FFFF, 32'd5, 32'hFFFF_FFFF, 32'd2,
                     1'b0, 1'b1);
        queue_report(pct_pkg::REQ_ABS, 32'd5, 32'd5, 0, 0, 32'd0, 32'd9, 1'b1, 1'b0);
        queue_report(pct_pkg::REQ_REL, 0, 0, 32'd5, 32'd5, 32'd9, 32'd0, 1'b1, 1'b0);
        queue_report(pct_pkg::REQ_ERROR, 0, 0, 0, 0, 32'd1, 32'd1, 1'b1, 1'b0);
        queue_report(pct_pkg::REQ_ABS, 32'd50, 32'd60, 0, 0, 32'd100, 32'd100, 1'b1, 1'b0);
        queue_report(pct_pkg::REQ_ABS, 32'd90, 32'd90, 0, 0, 32'd100, 32'd100, 1'b0, 1'b1);
        for (int i = 0; i < 9; i++)
            queue_report(pct_pkg::REQ_NOTREADY, 0, 0, 0, 0, 0, 0, 1'b0, i == 8);
        random_phase(40);

        // small screen, fast growth to a zero cap, stall on every not-ready
        write_all(16'd1, 16'd16384, 16'd31, 16'd1, 16'd65535, 16'd0, 16'd1);
        for (int i = 0; i < 4; i++)
            queue_report(pct_pkg::REQ_NOTREADY, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1);
        random_phase(60);

        // wide flat screen, large cap, zero step, long trigger
        write_all(16'd16384, 16'd1, 16'd1, 16'd1, 16'd0, 16'd65535, 16'd15);
        for (int i = 0; i < 32; i++)
            queue_report(pct_pkg::REQ_NOTREADY, 0, 0, 0, 0, 0, 0, 1'b0, i % 8 == 7);
        random_phase(60);

        // cap lowered below a grown delay
        write_all(16'd800, 16'd600, 16'd7, 16'd1, 16'd65535, 16'd65535, 16'd2);
        for (int i = 0; i < 4; i++)
            queue_report(pct_pkg::REQ_NOTREADY, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
        wait_idle();
        write_reg(pct_pkg::REG_CAP, 16'd1234);
        for (int i = 0; i < 4; i++)
            queue_report(pct_pkg::REQ_NOTREADY, 0, 0, 0, 0, 0, 0, 1'b0, i == 3);

        // random settings
        for (int p = 0; p < 6; p++) begin
            write_all(16'($urandom_range(1, 16384)), 16'($urandom_range(1, 16384)),
                      16'($urandom_range(1, 31)), 16'd1, 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(1, 15)));
            random_phase(45);
        end

        // drop the pointer mid-stream, then bring it back
        wait_idle();
        write_reg(pct_pkg::REG_ACTIVE, 16'd0);
        random_phase(10);
        wait_idle();
        write_reg(pct_pkg::REG_ACTIVE, 16'd1);
        random_phase(20);

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // sender: bursts of random length with random gaps
    logic in_taken = 1'b0;
    int   burst_left = 0, gap_left = 0;

    always @(posedge i_clk) begin
        in_taken <= i_valid && !o_stall;
    end

    always @(negedge i_clk) begin
        if (in_taken) void'(report_q.pop_front());
        if (!i_valid || in_taken) begin
            if (gap_left > 0 || report_q.size() == 0) begin
                if (gap_left > 0) gap_left--;
                i_valid <= 1'b0;
            end else begin
                i_valid <= 1'b1;
                i_req_type <= report_q[0].kind;
                i_abs_x <= report_q[0].ax;
                i_abs_y <= report_q[0].ay;
                i_rel_x <= report_q[0].rx;
                i_rel_y <= report_q[0].ry;
                i_divisor_x <= report_q[0].dx;
                i_divisor_y <= report_q[0].dy;
                i_button <= report_q[0].btn;
                i_last_in_poll <= report_q[0].last;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 20);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
                end
            end
        end
    end

    // receiver: random stall pattern, redrawn periodically from four modes
    int stall_mode = 0;

    always @(negedge i_clk) begin
        if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= cycles[1];
        endcase
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        t_cursor want;
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (cursor_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction at cycle %0d", cycles);
            end else begin
                want = cursor_q.pop_front();
                if (o_status !== want.status || o_stall_us !== want.stall_us ||
                    o_round_done !== want.done || o_cursor_x !== want.cx ||
                    o_cursor_y !== want.cy || o_holding !== want.hold ||
                    o_press !== want.press) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch at cycle %0d: exp st=%0d stall=%0d done=%0d ",
                                  "x=%0d y=%0d hold=%0d press=%0d got st=%0d stall=%0d ",
                                  "done=%0d x=%0d y=%0d hold=%0d press=%0d"},
                                 cycles, want.status, want.stall_us, want.done, want.cx,
                                 want.cy, want.hold, want.press, o_status, o_stall_us,
                                 o_round_done, o_cursor_x, o_cursor_y, o_holding, o_press);
                end
            end
        end
    end

endmodule
